>>> rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared widths, reset values, command and register codes for the seconds
// countdown timer.
// ----------------------------------------------------------------------------
package cdt_pkg;

   localparam int CmdWidth      = 3;
   localparam int StepWidth     = 7;
   localparam int CountWidth    = 10;
   localparam int DigitWidth    = 4;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 10;

   // Largest count the three digit display can show
   localparam logic [CountWidth-1:0] CountCap = 10'd999;

   // Reset values of the configuration registers and of the preset
   localparam logic [StepWidth-1:0]  ResetFastStep    = 7'd10;
   localparam logic [CountWidth-1:0] ResetMaxTime     = 10'd999;
   localparam logic [CountWidth-1:0] ResetMinTime     = 10'd5;
   localparam logic [CountWidth-1:0] ResetDefaultTime = 10'd60;
   localparam logic [CountWidth-1:0] ResetPreset      = 10'd60;

   // Command codes carried by a request transfer
   typedef enum logic [CmdWidth-1:0] {
      CMD_TICK   = 3'd0,
      CMD_INC    = 3'd1,
      CMD_DEC    = 3'd2,
      CMD_TOGGLE = 3'd3,
      CMD_RESET  = 3'd4
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FAST_STEP    = 2'd0,
      CSR_MAX_TIME     = 2'd1,
      CSR_MIN_TIME     = 2'd2,
      CSR_DEFAULT_TIME = 2'd3
   } csr_index_type;

   // Limit a register value to the displayable range
   function automatic logic [CountWidth-1:0] cap_count(input logic [CountWidth-1:0] v);
      cap_count = (v > CountCap) ? CountCap : v;
   endfunction

endpackage

>>> rtl/cdt_if.sv
// ----------------------------------------------------------------------------
// cdt_if
// Valid/ready channels of the countdown timer: command requests and
// per-command status responses.
// ----------------------------------------------------------------------------

// Command channel
interface cdt_req_if;
   logic                          valid;
   logic                          ready;
   logic [cdt_pkg::CmdWidth-1:0]  cmd;
   logic                          fast;
   logic                          to_default;

   modport source (output valid, output cmd, output fast, output to_default, input ready);
   modport sink   (input valid, input cmd, input fast, input to_default, output ready);
endinterface

// Status channel
interface cdt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cdt_pkg::CountWidth-1:0]  count;
   logic [cdt_pkg::DigitWidth-1:0]  digit_hundreds;
   logic [cdt_pkg::DigitWidth-1:0]  digit_tens;
   logic [cdt_pkg::DigitWidth-1:0]  digit_ones;
   logic                            running;
   logic                            done_res;
   logic                            timeout;
   logic                            preset_changed;

   modport source (output valid, output count, output digit_hundreds, output digit_tens,
                   output digit_ones, output running, output done_res, output timeout,
                   output preset_changed, input ready);
   modport sink   (input valid, input count, input digit_hundreds, input digit_tens,
                   input digit_ones, input running, input done_res, input timeout,
                   input preset_changed, output ready);
endinterface

>>> rtl/countdown_timer_with_preset.sv
// ----------------------------------------------------------------------------
// countdown_timer_with_preset
// Seconds countdown timer with a saved preset and a three digit readout.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transfer: second tick, increase,
//   decrease, start/pause toggle or reset (with optional load of the default
//   preset). rsp_chan returns exactly one status per command: the count,
//   its three decimal digits, running/finished flags, a timeout pulse and
//   a preset-changed flag.
//   csr_we/csr_index/csr_wdata write fast step, max, min and default time;
//   write them only while no command is in flight.
//   A command taken into the input register is presented on rsp_chan
//   once the state update loads the result register.
//   Throughput: one command per cycle while rsp_chan is not stalled; the
//   state update sits between the input register and the result register.
//   Reset (synchronous, active high) empties both registers, loads the
//   register reset values and puts the timer stopped and finished at 60.
//   When the receiver stalls, the result register holds; one more command
//   is taken into the input register, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module countdown_timer_with_preset (
   input  logic                                 clock,
   input  logic                                 reset,
   cdt_req_if.sink                              req_chan,
   cdt_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [cdt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [cdt_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // Configuration registers
   logic [cdt_pkg::StepWidth-1:0]  fast_step_ff;
   logic [cdt_pkg::CountWidth-1:0] max_time_ff;
   logic [cdt_pkg::CountWidth-1:0] min_time_ff;
   logic [cdt_pkg::CountWidth-1:0] default_time_ff;

   // Input register
   logic                          in_valid_ff;
   logic [cdt_pkg::CmdWidth-1:0]  in_cmd_ff;
   logic                          in_fast_ff;
   logic                          in_to_default_ff;

   // Timer state
   logic [cdt_pkg::CountWidth-1:0] remaining_ff, remaining_in;
   logic [cdt_pkg::CountWidth-1:0] preset_ff, preset_in;
   logic                           running_ff, running_in;
   logic                           done_ff, done_in;
   logic                           timeout_in, changed_in;

   // Result register
   logic                            out_valid_ff;
   logic [cdt_pkg::CountWidth-1:0]  out_count_ff;
   logic [cdt_pkg::DigitWidth-1:0]  out_hundreds_ff, out_tens_ff, out_ones_ff;
   logic                            out_running_ff, out_done_ff;
   logic                            out_timeout_ff, out_changed_ff;

   logic [cdt_pkg::DigitWidth-1:0]  hundreds_in, tens_in, ones_in;

   logic                            advance;
   logic                            req_xfer;
   logic                            update;
   logic [cdt_pkg::CountWidth-1:0]  step;
   logic [cdt_pkg::CountWidth-1:0]  hi_lim, lo_lim, def_time;
   logic [cdt_pkg::CountWidth:0]    sum;
   logic [cdt_pkg::CountWidth:0]    diff;

   // Handshake: the result register moves when empty or taken
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign update         = in_valid_ff && advance;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_step_ff    <= cdt_pkg::ResetFastStep;
         max_time_ff     <= cdt_pkg::ResetMaxTime;
         min_time_ff     <= cdt_pkg::ResetMinTime;
         default_time_ff <= cdt_pkg::ResetDefaultTime;
      end else if (csr_we) begin
         case (cdt_pkg::csr_index_type'(csr_index))
            cdt_pkg::CSR_FAST_STEP:    fast_step_ff    <= csr_wdata[cdt_pkg::StepWidth-1:0];
            cdt_pkg::CSR_MAX_TIME:     max_time_ff     <= csr_wdata[cdt_pkg::CountWidth-1:0];
            cdt_pkg::CSR_MIN_TIME:     min_time_ff     <= csr_wdata[cdt_pkg::CountWidth-1:0];
            cdt_pkg::CSR_DEFAULT_TIME: default_time_ff <= csr_wdata[cdt_pkg::CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff        <= req_chan.cmd;
         in_fast_ff       <= req_chan.fast;
         in_to_default_ff <= req_chan.to_default;
      end
   end

   // Adjust operands and limits
   assign step     = in_fast_ff ? cdt_pkg::CountWidth'(fast_step_ff) : cdt_pkg::CountWidth'(1);
   assign hi_lim   = cdt_pkg::cap_count(max_time_ff);
   assign lo_lim   = cdt_pkg::cap_count(min_time_ff);
   assign def_time = cdt_pkg::cap_count(default_time_ff);
   assign sum      = {1'b0, remaining_ff} + {1'b0, step};
   assign diff     = {1'b0, remaining_ff} - {1'b0, step};

   // Next state for the command in the input register
   always_comb begin
      remaining_in = remaining_ff;
      preset_in    = preset_ff;
      running_in   = running_ff;
      done_in      = done_ff;
      timeout_in   = 1'b0;
      changed_in   = 1'b0;
      case (cdt_pkg::cmd_type'(in_cmd_ff))
         cdt_pkg::CMD_TICK: begin
            if (running_ff) begin
               if (remaining_ff <= cdt_pkg::CountWidth'(1)) begin
                  remaining_in = '0;
                  running_in   = 1'b0;
                  done_in      = 1'b1;
                  timeout_in   = 1'b1;
               end else begin
                  remaining_in = remaining_ff - cdt_pkg::CountWidth'(1);
               end
            end
         end
         cdt_pkg::CMD_INC: begin
            remaining_in = (sum > {1'b0, hi_lim}) ? hi_lim : sum[cdt_pkg::CountWidth-1:0];
         end
         cdt_pkg::CMD_DEC: begin
            // borrow means the difference went negative
            if (diff[cdt_pkg::CountWidth] || (diff[cdt_pkg::CountWidth-1:0] < lo_lim)) begin
               remaining_in = lo_lim;
            end else begin
               remaining_in = diff[cdt_pkg::CountWidth-1:0];
            end
         end
         cdt_pkg::CMD_TOGGLE: begin
            running_in = !running_ff;
            if (!running_ff && done_ff) begin
               preset_in = remaining_ff;
               done_in   = 1'b0;
            end
         end
         cdt_pkg::CMD_RESET: begin
            running_in   = 1'b0;
            done_in      = 1'b1;
            remaining_in = preset_ff;
            if (in_to_default_ff && (preset_ff != def_time)) begin
               preset_in    = def_time;
               remaining_in = def_time;
               changed_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Decimal split of the new count
   cdt_digits u_digits (
      .value    (remaining_in),
      .hundreds (hundreds_in),
      .tens     (tens_in),
      .ones     (ones_in)
   );

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= cdt_pkg::ResetPreset;
         preset_ff    <= cdt_pkg::ResetPreset;
         running_ff   <= 1'b0;
         done_ff      <= 1'b1;
      end else if (update) begin
         remaining_ff <= remaining_in;
         preset_ff    <= preset_in;
         running_ff   <= running_in;
         done_ff      <= done_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         out_count_ff    <= remaining_in;
         out_hundreds_ff <= hundreds_in;
         out_tens_ff     <= tens_in;
         out_ones_ff     <= ones_in;
         out_running_ff  <= running_in;
         out_done_ff     <= done_in;
         out_timeout_ff  <= timeout_in;
         out_changed_ff  <= changed_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.count          = out_count_ff;
   assign rsp_chan.digit_hundreds = out_hundreds_ff;
   assign rsp_chan.digit_tens     = out_tens_ff;
   assign rsp_chan.digit_ones     = out_ones_ff;
   assign rsp_chan.running        = out_running_ff;
   assign rsp_chan.done_res       = out_done_ff;
   assign rsp_chan.timeout        = out_timeout_ff;
   assign rsp_chan.preset_changed = out_changed_ff;

endmodule

>>> rtl/cdt_digits.sv
// ----------------------------------------------------------------------------
// cdt_digits
// Splits a count of 0 to 999 into hundreds, tens and ones decimal digits
// using reciprocal multiplication by constants.
// ----------------------------------------------------------------------------
module cdt_digits (
   input  logic [cdt_pkg::CountWidth-1:0] value,
   output logic [cdt_pkg::DigitWidth-1:0] hundreds,
   output logic [cdt_pkg::DigitWidth-1:0] tens,
   output logic [cdt_pkg::DigitWidth-1:0] ones
);

   logic [15:0] h_prod;
   logic [9:0]  h_rem;
   logic [6:0]  rem;
   logic [14:0] t_prod;
   logic [6:0]  o_rem;

   // value/100 as value*41 >> 12, exact for 0..999
   assign h_prod   = 16'(value) * 16'd41;
   assign hundreds = h_prod[15:12];
   assign h_rem    = value - (10'(hundreds) * 10'd100);
   assign rem      = h_rem[6:0];

   // rem/10 as rem*205 >> 11, exact for 0..99
   assign t_prod = 15'(rem) * 15'd205;
   assign tens   = t_prod[14:11];
   assign o_rem  = rem - (7'(tens) * 7'd10);
   assign ones   = o_rem[3:0];

endmodule

>>> rtl/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks on the countdown timer status channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module cdt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic [cdt_pkg::CountWidth-1:0]  count,
   input logic [cdt_pkg::DigitWidth-1:0]  digit_hundreds,
   input logic [cdt_pkg::DigitWidth-1:0]  digit_tens,
   input logic [cdt_pkg::DigitWidth-1:0]  digit_ones,
   input logic                            running,
   input logic                            done_res,
   input logic                            timeout,
   input logic                            preset_changed
);

   // No status straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("status valid on the cycle after reset");

   // Digits spell the count
   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (digit_hundreds <= 4'd9) && (digit_tens <= 4'd9) &&
                    (digit_ones <= 4'd9) &&
                    ((10'(digit_hundreds) * 10'd100) + (10'(digit_tens) * 10'd10) +
                     10'(digit_ones) == count))
      else $error("decimal digits disagree with count");

   // A timeout leaves the timer stopped and finished at zero
   a_timeout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && timeout) |-> (count == '0) && !running && done_res && !preset_changed)
      else $error("timeout with inconsistent status");

   // Running and finished are never both set
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(running && done_res))
      else $error("running while finished");

   // A preset load, which only a reset command makes, leaves the timer stopped and finished
   a_preset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && preset_changed) |-> done_res && !running)
      else $error("preset changed without a stopped timer");

endmodule

bind countdown_timer_with_preset cdt_checker u_cdt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .count          (rsp_chan.count),
   .digit_hundreds (rsp_chan.digit_hundreds),
   .digit_tens     (rsp_chan.digit_tens),
   .digit_ones     (rsp_chan.digit_ones),
   .running        (rsp_chan.running),
   .done_res       (rsp_chan.done_res),
   .timeout        (rsp_chan.timeout),
   .preset_changed (rsp_chan.preset_changed)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seconds countdown timer. A short command table
// with hand-written results comes first. Phases of random countdown
// sequences follow, each under its own register setting. Every status
// transfer is checked field by field against its table result or an in-bench timer model.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HalfPeriod     = 10;
   localparam int ResetCycles    = 10;
   localparam int DrainCycles    = 4;
   localparam int LongHoldCycles = 300;
   localparam int CycleLimit     = 200000;
   localparam int PhaseItems     = 160;
   localparam int NumPhases      = 8;
   localparam int NumRows        = 31;

   // Spare command codes, which only report the current state
   localparam logic [cdt_pkg::CmdWidth-1:0] CmdUnused5 = 3'd5;
   localparam logic [cdt_pkg::CmdWidth-1:0] CmdUnused7 = 3'd7;

   typedef struct packed {
      logic [cdt_pkg::CountWidth-1:0] count;
      logic [cdt_pkg::DigitWidth-1:0] hundreds;
      logic [cdt_pkg::DigitWidth-1:0] tens;
      logic [cdt_pkg::DigitWidth-1:0] ones;
      logic                           running;
      logic                           done_res;
      logic                           timeout;
      logic                           preset_changed;
   } timer_status_type;

   typedef struct packed {
      logic                             is_csr;
      cdt_pkg::csr_index_type           reg_sel;
      logic [cdt_pkg::CsrDataWidth-1:0] wdata;
      logic [cdt_pkg::CmdWidth-1:0]     cmd;
      logic                             fast;
      logic                             to_default;
      logic                             known;
      timer_status_type                 want;
   } table_row_type;

   // Table row builders
   function automatic table_row_type csr_row(cdt_pkg::csr_index_type sel,
                                             logic [cdt_pkg::CsrDataWidth-1:0] data);
      table_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.reg_sel = sel;
      r.wdata = data;
      return r;
   endfunction

   function automatic table_row_type cmd_row(logic [cdt_pkg::CmdWidth-1:0] c, logic f,
                                             logic d);
      table_row_type r;
      r = '0;
      r.cmd = c;
      r.fast = f;
      r.to_default = d;
      return r;
   endfunction

   function automatic table_row_type known_row(logic [cdt_pkg::CmdWidth-1:0] c, logic f,
                                               logic d,
                                               logic [cdt_pkg::CountWidth-1:0] cnt,
                                               logic [cdt_pkg::DigitWidth-1:0] h,
                                               logic [cdt_pkg::DigitWidth-1:0] t,
                                               logic [cdt_pkg::DigitWidth-1:0] o,
                                               logic run, logic fin, logic tmo, logic chg);
      table_row_type r;
      r = cmd_row(c, f, d);
      r.known = 1'b1;
      r.want = '{cnt, h, t, o, run, fin, tmo, chg};
      return r;
   endfunction

   // Directed commands; fields after the count are digits, run, done, timeout, reload
   localparam table_row_type DirectedRows [NumRows] = '{
      // straight out of reset: stopped and finished at 60
      known_row(cdt_pkg::CMD_TICK,   0, 0, 10'd60,  4'd0, 4'd6, 4'd0, 0, 1, 0, 0),
      known_row(cdt_pkg::CMD_INC,    0, 0, 10'd61,  4'd0, 4'd6, 4'd1, 0, 1, 0, 0),
      known_row(cdt_pkg::CMD_INC,    1, 0, 10'd71,  4'd0, 4'd7, 4'd1, 0, 1, 0, 0),
      known_row(cdt_pkg::CMD_DEC,    1, 0, 10'd61,  4'd0, 4'd6, 4'd1, 0, 1, 0, 0),
      // default equal to the preset: no reload flagged
      known_row(cdt_pkg::CMD_RESET,  0, 1, 10'd60,  4'd0, 4'd6, 4'd0, 0, 1, 0, 0),
      known_row(CmdUnused5,          0, 0, 10'd60,  4'd0, 4'd6, 4'd0, 0, 1, 0, 0),
      known_row(CmdUnused7,          1, 1, 10'd60,  4'd0, 4'd6, 4'd0, 0, 1, 0, 0),
      // start saves the preset, then pause and resume
      known_row(cdt_pkg::CMD_TOGGLE, 0, 0, 10'd60,  4'd0, 4'd6, 4'd0, 1, 0, 0, 0),
      known_row(cdt_pkg::CMD_TICK,   0, 0, 10'd59,  4'd0, 4'd5, 4'd9, 1, 0, 0, 0),
      known_row(cdt_pkg::CMD_TOGGLE, 0, 0, 10'd59,  4'd0, 4'd5, 4'd9, 0, 0, 0, 0),
      cmd_row(cdt_pkg::CMD_TOGGLE, 0, 0),
      // floor at zero with the widest fast step, then time out
      csr_row(cdt_pkg::CSR_MIN_TIME, 10'd0),
      csr_row(cdt_pkg::CSR_FAST_STEP, 10'd127),
      known_row(cdt_pkg::CMD_DEC,    1, 0, 10'd0,   4'd0, 4'd0, 4'd0, 1, 0, 0, 0),
      known_row(cdt_pkg::CMD_TICK,   0, 0, 10'd0,   4'd0, 4'd0, 4'd0, 0, 1, 1, 0),
      known_row(cdt_pkg::CMD_TICK,   0, 0, 10'd0,   4'd0, 4'd0, 4'd0, 0, 1, 0, 0),
      known_row(cdt_pkg::CMD_RESET,  0, 0, 10'd60,  4'd0, 4'd6, 4'd0, 0, 1, 0, 0),
      // registers above 999 act as 999
      csr_row(cdt_pkg::CSR_DEFAULT_TIME, 10'd1023),
      known_row(cdt_pkg::CMD_RESET,  0, 1, 10'd999, 4'd9, 4'd9, 4'd9, 0, 1, 0, 1),
      known_row(cdt_pkg::CMD_INC,    1, 0, 10'd999, 4'd9, 4'd9, 4'd9, 0, 1, 0, 0),
      csr_row(cdt_pkg::CSR_MAX_TIME, 10'd1023),
      csr_row(cdt_pkg::CSR_MIN_TIME, 10'd1023),
      known_row(cdt_pkg::CMD_DEC,    1, 0, 10'd999, 4'd9, 4'd9, 4'd9, 0, 1, 0, 0),
      // zero fast step
      csr_row(cdt_pkg::CSR_FAST_STEP, 10'd0),
      cmd_row(cdt_pkg::CMD_INC, 1, 0),
      // count above the maximum is pulled down to it
      csr_row(cdt_pkg::CSR_MAX_TIME, 10'd1),
      known_row(cdt_pkg::CMD_INC,    0, 0, 10'd1,   4'd0, 4'd0, 4'd1, 0, 1, 0, 0),
      cmd_row(cdt_pkg::CMD_TOGGLE, 0, 0),
      known_row(cdt_pkg::CMD_TICK,   0, 0, 10'd0,   4'd0, 4'd0, 4'd0, 0, 1, 1, 0),
      known_row(cdt_pkg::CMD_RESET,  0, 1, 10'd999, 4'd9, 4'd9, 4'd9, 0, 1, 0, 1),
      known_row(cdt_pkg::CMD_RESET,  1, 1, 10'd999, 4'd9, 4'd9, 4'd9, 0, 1, 0, 0)
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [cdt_pkg::CsrIndexWidth-1:0] csr_index;
   logic [cdt_pkg::CsrDataWidth-1:0]  csr_wdata;

   cdt_req_if req_chan();
   cdt_rsp_if rsp_chan();

   countdown_timer_with_preset dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Expectation riding along with the offered command (table rows only)
   logic             offer_known;
   timer_status_type offer_want;

   bit steady_flow  = 1'b0;
   bit hold_off_req = 1'b0;

   timer_status_type status_q [$];
   int error_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int timeouts_seen   = 0;
   int reloads_seen    = 0;
   int reg_writes      = 0;
   int cycle_count;

   // Timer model state and registers
   logic [cdt_pkg::StepWidth-1:0]  cfg_fast_step    = cdt_pkg::ResetFastStep;
   logic [cdt_pkg::CountWidth-1:0] cfg_max_time     = cdt_pkg::ResetMaxTime;
   logic [cdt_pkg::CountWidth-1:0] cfg_min_time     = cdt_pkg::ResetMinTime;
   logic [cdt_pkg::CountWidth-1:0] cfg_default_time = cdt_pkg::ResetDefaultTime;
   logic [cdt_pkg::CountWidth-1:0] secs_left        = cdt_pkg::ResetPreset;
   logic [cdt_pkg::CountWidth-1:0] saved_preset     = cdt_pkg::ResetPreset;
   logic                           timer_on         = 1'b0;
   logic                           timer_done       = 1'b1;

   function automatic int limit_display(logic [cdt_pkg::CountWidth-1:0] v);
      return (v > cdt_pkg::CountCap) ? int'(cdt_pkg::CountCap) : int'(v);
   endfunction

   // Apply one command to the model and return the status it should report
   function automatic timer_status_type advance_timer(logic [cdt_pkg::CmdWidth-1:0] c,
                                                      logic f, logic d);
      timer_status_type st;
      int step;
      int sum;
      int bound;
      st = '0;
      step = f ? int'(cfg_fast_step) : 1;
      case (c)
         cdt_pkg::CMD_TICK: begin
            if (timer_on) begin
               if (secs_left <= 1) begin
                  secs_left = '0;
                  timer_on = 1'b0;
                  timer_done = 1'b1;
                  st.timeout = 1'b1;
               end else begin
                  secs_left = secs_left - 1'b1;
               end
            end
         end
         cdt_pkg::CMD_INC: begin
            bound = limit_display(cfg_max_time);
            sum = int'(secs_left) + step;
            secs_left = cdt_pkg::CountWidth'((sum > bound) ? bound : sum);
         end
         cdt_pkg::CMD_DEC: begin
            // may go negative before the clamp; the minimum can also raise the count
            bound = limit_display(cfg_min_time);
            sum = int'(secs_left) - step;
            secs_left = cdt_pkg::CountWidth'((sum < bound) ? bound : sum);
         end
         cdt_pkg::CMD_TOGGLE: begin
            timer_on = !timer_on;
            if (timer_on && timer_done) begin
               saved_preset = secs_left;
               timer_done = 1'b0;
            end
         end
         cdt_pkg::CMD_RESET: begin
            bound = limit_display(cfg_default_time);
            timer_on = 1'b0;
            timer_done = 1'b1;
            secs_left = saved_preset;
            if (d && int'(saved_preset) != bound) begin
               saved_preset = cdt_pkg::CountWidth'(bound);
               secs_left = saved_preset;
               st.preset_changed = 1'b1;
            end
         end
         default: ;
      endcase
      st.count = secs_left;
      st.hundreds = cdt_pkg::DigitWidth'(int'(secs_left) / 100 % 10);
      st.tens = cdt_pkg::DigitWidth'(int'(secs_left) / 10 % 10);
      st.ones = cdt_pkg::DigitWidth'(int'(secs_left) % 10);
      st.running = timer_on;
      st.done_res = timer_done;
      return st;
   endfunction

   task automatic check_field(input string field, input logic [cdt_pkg::CountWidth-1:0] want,
                              input logic [cdt_pkg::CountWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #HalfPeriod clock = ~clock;
   end

   // Model update on register writes and command transfers, check on status transfers
   always @(posedge clock) begin : monitor
      timer_status_type want;
      timer_status_type got;
      if (!reset) begin
         if (csr_we) begin
            reg_writes++;
            case (csr_index)
               cdt_pkg::CSR_FAST_STEP:    cfg_fast_step = csr_wdata[cdt_pkg::StepWidth-1:0];
               cdt_pkg::CSR_MAX_TIME:     cfg_max_time = csr_wdata;
               cdt_pkg::CSR_MIN_TIME:     cfg_min_time = csr_wdata;
               cdt_pkg::CSR_DEFAULT_TIME: cfg_default_time = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            want = advance_timer(req_chan.cmd, req_chan.fast, req_chan.to_default);
            if (offer_known)
               want = offer_want;
            status_q.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.count, rsp_chan.digit_hundreds, rsp_chan.digit_tens,
                    rsp_chan.digit_ones, rsp_chan.running, rsp_chan.done_res,
                    rsp_chan.timeout, rsp_chan.preset_changed};
            if (status_q.size() == 0) begin
               $display("%0t: status transfer with none expected, actual count %0d",
                        $time, got.count);
               error_count++;
            end else begin
               want = status_q.pop_front();
               results_checked++;
               if (got.timeout === 1'b1)
                  timeouts_seen++;
               if (got.preset_changed === 1'b1)
                  reloads_seen++;
               check_field("count", want.count, got.count);
               check_field("digit_hundreds", cdt_pkg::CountWidth'(want.hundreds),
                           cdt_pkg::CountWidth'(got.hundreds));
               check_field("digit_tens", cdt_pkg::CountWidth'(want.tens),
                           cdt_pkg::CountWidth'(got.tens));
               check_field("digit_ones", cdt_pkg::CountWidth'(want.ones),
                           cdt_pkg::CountWidth'(got.ones));
               check_field("running", cdt_pkg::CountWidth'(want.running),
                           cdt_pkg::CountWidth'(got.running));
               check_field("done_res", cdt_pkg::CountWidth'(want.done_res),
                           cdt_pkg::CountWidth'(got.done_res));
               check_field("timeout", cdt_pkg::CountWidth'(want.timeout),
                           cdt_pkg::CountWidth'(got.timeout));
               check_field("preset_changed", cdt_pkg::CountWidth'(want.preset_changed),
                           cdt_pkg::CountWidth'(got.preset_changed));
            end
         end
      end
   end

   // Status side pacing, with one long hold-off on request
   initial begin : sink_pacing
      int held;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            for (held = 0; held < LongHoldCycles; held++)
               @(posedge clock);
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= steady_flow || ($urandom_range(0, 99) >= 38);
         end
      end
   end

   // Watchdog
   initial begin
      for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++)
         @(posedge clock);
      $display("%0t: cycle limit reached with %0d results outstanding", $time, status_q.size());
      $display("Some tests failed");
      $finish;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Offer one command and hold it until the transfer
   task automatic offer_cmd(input logic [cdt_pkg::CmdWidth-1:0] c, input logic f,
                            input logic d, input logic known, input timer_status_type want);
      if (!steady_flow && $urandom_range(0, 99) < 38) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 38);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= c;
      req_chan.fast       <= f;
      req_chan.to_default <= d;
      offer_known         <= known;
      offer_want          <= want;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic offer_plain(input logic [cdt_pkg::CmdWidth-1:0] c, input logic f,
                              input logic d);
      offer_cmd(c, f, d, 1'b0, '0);
   endtask

   // Stop offering and let every outstanding status come back
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (status_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input cdt_pkg::csr_index_type sel,
                            input logic [cdt_pkg::CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timer_regs(input logic [cdt_pkg::CsrDataWidth-1:0] step,
                                 input logic [cdt_pkg::CsrDataWidth-1:0] top,
                                 input logic [cdt_pkg::CsrDataWidth-1:0] bottom,
                                 input logic [cdt_pkg::CsrDataWidth-1:0] dflt);
      write_reg(cdt_pkg::CSR_FAST_STEP, step);
      write_reg(cdt_pkg::CSR_MAX_TIME, top);
      write_reg(cdt_pkg::CSR_MIN_TIME, bottom);
      write_reg(cdt_pkg::CSR_DEFAULT_TIME, dflt);
   endtask

   // Mostly complete countdowns with random content, some loose noise
   task automatic run_phase(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 80) begin
            // reset, set the time, start, tick down with the odd interruption
            offer_plain(cdt_pkg::CMD_RESET, coin(), coin());
            repeat ($urandom_range(0, 4))
               offer_plain(coin() ? cdt_pkg::CMD_INC : cdt_pkg::CMD_DEC, coin(), coin());
            offer_plain(cdt_pkg::CMD_TOGGLE, coin(), coin());
            repeat ($urandom_range(1, 40)) begin
               if ($urandom_range(0, 99) < 8)
                  offer_plain(cdt_pkg::CmdWidth'($urandom_range(0, (1 << cdt_pkg::CmdWidth) - 1)),
                              coin(), coin());
               else
                  offer_plain(cdt_pkg::CMD_TICK, coin(), coin());
            end
         end else begin
            repeat ($urandom_range(1, 10))
               offer_plain(cdt_pkg::CmdWidth'($urandom_range(0, (1 << cdt_pkg::CmdWidth) - 1)),
                           coin(), coin());
         end
      end
   endtask

   // Stimulus
   initial begin : stimulus
      int row;
      int ph;
      table_row_type r;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = cdt_pkg::CMD_TICK;
      req_chan.fast       = 1'b0;
      req_chan.to_default = 1'b0;
      csr_we              = 1'b0;
      csr_index           = cdt_pkg::CSR_FAST_STEP;
      csr_wdata           = '0;
      offer_known         = 1'b0;
      offer_want          = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (row = 0; row < NumRows; row++) begin
         r = DirectedRows[row];
         if (r.is_csr) begin
            wait_quiet();
            write_reg(r.reg_sel, r.wdata);
         end else begin
            offer_cmd(r.cmd, r.fast, r.to_default, r.known, r.want);
         end
      end

      // Random phases, each under its own register setting
      for (ph = 0; ph < NumPhases; ph++) begin
         wait_quiet();
         case (ph)
            0: set_timer_regs(10'd1, 10'd30, 10'd0, 10'd20);
            1: set_timer_regs(10'd127, 10'd1023, 10'd0, 10'd0);
            2: set_timer_regs(10'd0, 10'd999, 10'd1023, 10'd1023);
            3: set_timer_regs(10'd5, 10'd50, 10'd1, 10'd50);
            default: set_timer_regs(cdt_pkg::CsrDataWidth'($urandom_range(0, 1023)),
                                    cdt_pkg::CsrDataWidth'(($urandom_range(0, 3) == 0) ?
                                                           $urandom_range(0, 1023) :
                                                           $urandom_range(0, 80)),
                                    cdt_pkg::CsrDataWidth'($urandom_range(0, 10)),
                                    cdt_pkg::CsrDataWidth'($urandom_range(0, 80)));
         endcase
         steady_flow = (ph == 3);
         if (ph == 1)
            hold_off_req = 1'b1;
         run_phase(PhaseItems);
      end
      steady_flow = 1'b0;
      wait_quiet();

      $display("Covered %0d commands (%0d table rows) across %0d register writes.",
               items_sent, NumRows, reg_writes);
      $display("Checked %0d status transfers, %0d with timeout, %0d with a preset reload.",
               results_checked, timeouts_seen, reloads_seen);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
rtl/cdt_pkg.sv
rtl/cdt_if.sv
rtl/cdt_digits.sv
rtl/countdown_timer_with_preset.sv
rtl/cdt_checker.sv
dv/tb_top.sv
